### sv/cdab_pkg.sv
`timescale 1ns / 1ps

package cdab_pkg;

    localparam int MAX_DIM  = 4096;
    localparam int COORD_W  = $clog2(MAX_DIM);
    localparam int SIZE_W   = COORD_W + 1;

    localparam int CHAN_W   = 8;
    localparam int COLOR_W  = 3 * CHAN_W;
    localparam int SQ_W     = 2 * CHAN_W;
    localparam int DIST_W   = SQ_W + 2;
    localparam int PROX_W   = 7;
    localparam int SCALED_W = 25;

    localparam int LINE_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [DIST_W-1:0]   FULL_DIST = DIST_W'(255 * 255 * 3);
    localparam logic [SCALED_W-1:0] PERCENT   = SCALED_W'(100);

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROXIMITY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd2;

    localparam logic [COLOR_W-1:0] TARGET_RESET = '1;
    localparam logic [PROX_W-1:0]  PROX_RESET   = '0;
    localparam logic [LINE_W-1:0]  LINE_RESET   = LINE_W'(MAX_DIM);

    // result tdata layout; the struct below lists the highest bit first
    localparam int OUT_BITS  = 4 * COORD_W + 2 * SIZE_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int IN_TDATA_W  = ((COLOR_W + 7) / 8) * 8;

    typedef struct packed {
        logic                any_dirty;
        logic [SIZE_W-1:0]   crop_height;
        logic [SIZE_W-1:0]   crop_width;
        logic [COORD_W-1:0]  box_bottom;
        logic [COORD_W-1:0]  box_right;
        logic [COORD_W-1:0]  box_top;
        logic [COORD_W-1:0]  box_left;
    } box_result_t;

    function automatic logic [SQ_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

### sv/color_distance_autocrop_box_top.sv
`timescale 1ns / 1ps

// Color distance autocrop: finds the bounding box of pixels whose squared distance
// from a background color exceeds a percentage of the squared black-to-white one.
// Input stream: one RGB pixel per transaction in raster order, s_tdata[23:0]
// holds red 23:16, green 15:8, blue 7:0; s_tlast marks the frame's last pixel.
// Column and row are counted internally, the column wraps at line_width.
// Result stream: one transaction per frame, issued for the pixel with s_tlast.
// m_tvalid rises once the last pixel has passed the input register, the
// squared-distance register and the box update into the output register.
// Throughput is one pixel per cycle while s_tready is high. Configuration is
// written through cfg_we/cfg_index/cfg_wdata; the user must write it only while no
// frame is in flight, and the block itself does not enforce this.
// Reset (synchronous, aresetn low) restores register defaults and clears the
// counters and the box. If the receiver stalls, a waiting result holds in the
// output register and pixels keep flowing; only a second frame end stalls
// s_tready until the waiting result is taken.
module color_distance_autocrop_box_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cdab_pkg::IN_TDATA_W-1:0]     s_tdata,   // pixel_color
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // box_left, box_top, box_right, box_bottom, crop_width, crop_height, any_dirty
    output logic [cdab_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_we,
    input  logic [cdab_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cdab_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int CW = cdab_pkg::COORD_W;
    localparam int SW = cdab_pkg::SIZE_W;

    // configuration
    logic [cdab_pkg::COLOR_W-1:0]  target_reg;
    logic [cdab_pkg::PROX_W-1:0]   prox_reg;
    logic [cdab_pkg::LINE_W-1:0]   line_reg;
    logic [cdab_pkg::SCALED_W-1:0] thresh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= cdab_pkg::TARGET_RESET;
            prox_reg   <= cdab_pkg::PROX_RESET;
            line_reg   <= cdab_pkg::LINE_RESET;
            thresh_reg <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    cdab_pkg::REG_TARGET_COLOR: target_reg <= cfg_wdata[cdab_pkg::COLOR_W-1:0];
                    cdab_pkg::REG_PROXIMITY:    prox_reg   <= cfg_wdata[cdab_pkg::PROX_W-1:0];
                    cdab_pkg::REG_LINE_WIDTH:   line_reg   <= cfg_wdata[cdab_pkg::LINE_W-1:0];
                    default: ;
                endcase
            end
            thresh_reg <= cdab_pkg::SCALED_W'(prox_reg)
                        * cdab_pkg::SCALED_W'(cdab_pkg::FULL_DIST);
        end
    end

    logic [cdab_pkg::LINE_W-1:0] eff_width;
    always_comb begin
        if (line_reg == '0)
            eff_width = cdab_pkg::LINE_W'(1);
        else if (line_reg > cdab_pkg::LINE_W'(cdab_pkg::MAX_DIM))
            eff_width = cdab_pkg::LINE_W'(cdab_pkg::MAX_DIM);
        else
            eff_width = line_reg;
    end

    // pipeline control
    logic p1_valid_reg, p2_valid_reg;
    logic p1_last_reg, p2_last_reg;
    logic [cdab_pkg::COLOR_W-1:0] p1_pix_reg;
    logic [cdab_pkg::DIST_W-1:0]  p2_dist_reg;
    logic out_valid_reg;
    cdab_pkg::box_result_t out_data_reg;

    logic out_free, p2_fire, p2_take;
    assign out_free = !out_valid_reg || m_tready;
    assign p2_fire  = p2_valid_reg && (!p2_last_reg || out_free);
    assign p2_take  = !p2_valid_reg || p2_fire;
    assign s_tready = !p1_valid_reg || p2_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            if (s_tready) p1_valid_reg <= s_tvalid;
            if (p2_take)  p2_valid_reg <= p1_valid_reg;
        end
    end

    logic [cdab_pkg::DIST_W-1:0] dist_next;
    always_comb begin
        dist_next = cdab_pkg::DIST_W'(cdab_pkg::chan_sq(p1_pix_reg[23:16], target_reg[23:16]))
                  + cdab_pkg::DIST_W'(cdab_pkg::chan_sq(p1_pix_reg[15:8],  target_reg[15:8]))
                  + cdab_pkg::DIST_W'(cdab_pkg::chan_sq(p1_pix_reg[7:0],   target_reg[7:0]));
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            p1_pix_reg  <= s_tdata[cdab_pkg::COLOR_W-1:0];
            p1_last_reg <= s_tlast;
        end
        if (p2_take && p1_valid_reg) begin
            p2_dist_reg <= dist_next;
            p2_last_reg <= p1_last_reg;
        end
    end

    // box tracking
    logic [CW-1:0] col_reg, row_reg, min_col_reg, max_col_reg, min_row_reg, max_row_reg;
    logic          seen_reg;
    logic [CW-1:0] min_col_next, max_col_next, min_row_next, max_row_next;
    logic          seen_next, dirty;
    logic [cdab_pkg::SCALED_W-1:0] scaled;
    cdab_pkg::box_result_t result;

    assign scaled = cdab_pkg::SCALED_W'(p2_dist_reg) * cdab_pkg::PERCENT;
    assign dirty  = scaled > thresh_reg;

    always_comb begin
        min_col_next = min_col_reg;
        max_col_next = max_col_reg;
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        seen_next    = seen_reg;
        if (dirty) begin
            if (!seen_reg || col_reg < min_col_reg) min_col_next = col_reg;
            if (!seen_reg || col_reg > max_col_reg) max_col_next = col_reg;
            if (!seen_reg || row_reg < min_row_reg) min_row_next = row_reg;
            if (!seen_reg || row_reg > max_row_reg) max_row_next = row_reg;
            seen_next = 1'b1;
        end
        if (seen_next) begin
            result.box_left   = min_col_next;
            result.box_top    = min_row_next;
            result.box_right  = max_col_next;
            result.box_bottom = max_row_next;
        end else begin
            result.box_left   = '0;
            result.box_top    = '0;
            result.box_right  = '0;
            result.box_bottom = '0;
        end
        result.crop_width  = SW'(result.box_right) - SW'(result.box_left) + SW'(1);
        result.crop_height = SW'(result.box_bottom) - SW'(result.box_top) + SW'(1);
        result.any_dirty   = seen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            min_col_reg <= '1;
            max_col_reg <= '0;
            min_row_reg <= '1;
            max_row_reg <= '0;
            seen_reg    <= 1'b0;
        end else if (p2_fire) begin
            if (p2_last_reg) begin
                col_reg     <= '0;
                row_reg     <= '0;
                min_col_reg <= '1;
                max_col_reg <= '0;
                min_row_reg <= '1;
                max_row_reg <= '0;
                seen_reg    <= 1'b0;
            end else begin
                min_col_reg <= min_col_next;
                max_col_reg <= max_col_next;
                min_row_reg <= min_row_next;
                max_row_reg <= max_row_next;
                seen_reg    <= seen_next;
                if ((cdab_pkg::LINE_W'(col_reg) + cdab_pkg::LINE_W'(1)) >= eff_width) begin
                    col_reg <= '0;
                    // row saturates at the last addressable row
                    if (row_reg != '1) row_reg <= row_reg + CW'(1);
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (p2_fire && p2_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_fire && p2_last_reg) out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = cdab_pkg::OUT_TDATA_W'(out_data_reg);

endmodule

### sv/cdab_checker.sv
`timescale 1ns / 1ps

module cdab_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [cdab_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int SW = cdab_pkg::SIZE_W;

    cdab_pkg::box_result_t res;
    assign res = m_tdata[cdab_pkg::OUT_BITS-1:0];

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    a_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res.crop_width == SW'(res.box_right) - SW'(res.box_left) + SW'(1))
                  && (res.crop_height == SW'(res.box_bottom) - SW'(res.box_top) + SW'(1)))
        else $error("crop size does not match box");

    a_empty_box: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res.any_dirty |-> res.box_left == '0 && res.box_top == '0
                                     && res.box_right == '0 && res.box_bottom == '0)
        else $error("clean frame reports a nonzero box");

    a_ordered_box: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.any_dirty |-> res.box_left <= res.box_right
                                   && res.box_top <= res.box_bottom)
        else $error("box corners out of order");

endmodule

bind color_distance_autocrop_box_top cdab_checker u_cdab_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
